// ===== design/kmd_pkg.sv =====
// ----------------------------------------------------------------------------
// kmd_pkg
// Shared widths, record layout, command and status types of the merge unit.
// ----------------------------------------------------------------------------
package kmd_pkg;

    localparam int MAX_SOURCES = 16;
    localparam int IDX_W       = $clog2(MAX_SOURCES);
    localparam int CNT_W       = IDX_W + 1;

    // record field widths
    localparam int ID_W   = 32;
    localparam int DIFF_W = 16;
    localparam int REC_W  = 5 * ID_W + DIFF_W + 1;
    // heap entry: record, then source index as the final tie-break
    localparam int ENT_W  = REC_W + IDX_W;

    // record layout, most significant field first
    localparam int FR_LSB  = REC_W - ID_W;
    localparam int SR_LSB  = FR_LSB - ID_W;
    localparam int FO_LSB  = SR_LSB - ID_W;
    localparam int LEN_LSB = FO_LSB - ID_W;
    localparam int SO_LSB  = LEN_LSB - ID_W;
    localparam int DC_LSB  = SO_LSB - DIFF_W;

    // heap write data select
    localparam logic [1:0] WR_CARRY = 2'd0;
    localparam logic [1:0] WR_RDA   = 2'd1;
    localparam logic [1:0] WR_RDB   = 2'd2;

    // result kinds
    localparam logic KIND_RECORD  = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    typedef struct packed {
        logic             ld_carry_in;
        logic [IDX_W-1:0] in_src;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr_a;
        logic [IDX_W-1:0] rd_addr_b;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [1:0]       wr_sel;
        logic             ld_carry_a;
        logic             ld_popped_b;
        logic             ld_pending;
        logic             out_ld;
        logic             out_kind;
        logic [IDX_W-1:0] out_src;
        logic             out_pending;
        logic             out_done;
        logic             out_last;
    } t_cmd;

    typedef struct packed {
        logic             c_lt_a;
        logic             a_lt_c;
        logic             b_lt_c;
        logic             b_lt_a;
        logic             pair_eq;
        logic             longer;
        logic [IDX_W-1:0] popped_src;
    } t_stat;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] src;
        logic [REC_W-1:0] rec;
        logic             done;
        logic             last;
    } t_res;

endpackage

// ===== design/kmd_if.sv =====
// ----------------------------------------------------------------------------
// kmd_if
// Valid/ready channels for source records and merge results.
// ----------------------------------------------------------------------------
interface kmd_in_if;
    logic                       valid;
    logic                       ready;
    logic [kmd_pkg::ID_W-1:0]   in_first_read;
    logic [kmd_pkg::ID_W-1:0]   in_second_read;
    logic [kmd_pkg::ID_W-1:0]   in_first_offset;
    logic [kmd_pkg::ID_W-1:0]   in_overlap_length;
    logic [kmd_pkg::ID_W-1:0]   in_second_offset;
    logic [kmd_pkg::DIFF_W-1:0] in_difference_count;
    logic                       in_strand;
    logic                       source_empty;

    modport source (output valid, in_first_read, in_second_read, in_first_offset,
                    in_overlap_length, in_second_offset, in_difference_count,
                    in_strand, source_empty, input ready);
    modport sink   (input valid, in_first_read, in_second_read, in_first_offset,
                    in_overlap_length, in_second_offset, in_difference_count,
                    in_strand, source_empty, output ready);
endinterface

interface kmd_out_if;
    logic                        valid;
    logic                        ready;
    logic                        result_kind;
    logic [kmd_pkg::IDX_W-1:0]   request_source;
    logic [kmd_pkg::ID_W-1:0]    out_first_read;
    logic [kmd_pkg::ID_W-1:0]    out_second_read;
    logic [kmd_pkg::ID_W-1:0]    out_first_offset;
    logic [kmd_pkg::ID_W-1:0]    out_overlap_length;
    logic [kmd_pkg::ID_W-1:0]    out_second_offset;
    logic [kmd_pkg::DIFF_W-1:0]  out_difference_count;
    logic                        out_strand;
    logic                        merge_done;
    logic                        last_of_step;

    modport source (output valid, result_kind, request_source, out_first_read,
                    out_second_read, out_first_offset, out_overlap_length,
                    out_second_offset, out_difference_count, out_strand,
                    merge_done, last_of_step, input ready);
    modport sink   (input valid, result_kind, request_source, out_first_read,
                    out_second_read, out_first_offset, out_overlap_length,
                    out_second_offset, out_difference_count, out_strand,
                    merge_done, last_of_step, output ready);
endinterface

// ===== design/kmd_ram.sv =====
// ----------------------------------------------------------------------------
// kmd_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module kmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// ===== design/kmd_ctrl.sv =====
// ----------------------------------------------------------------------------
// kmd_ctrl
// Sequencer: fill phase, heap sift up and down, dedup and result issue.
// ----------------------------------------------------------------------------
module kmd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [kmd_pkg::CNT_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_empty,
    output logic                  o_in_ready,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    input  kmd_pkg::t_stat        i_stat,
    output kmd_pkg::t_cmd         o_cmd
);
    import kmd_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_PUSH_RD  = 4'd1;
    localparam logic [3:0] S_PUSH_CMP = 4'd2;
    localparam logic [3:0] S_FILL_NXT = 4'd3;
    localparam logic [3:0] S_DEDUP    = 4'd4;
    localparam logic [3:0] S_ADV      = 4'd5;
    localparam logic [3:0] S_POP_LD   = 4'd6;
    localparam logic [3:0] S_SIFT_RD  = 4'd7;
    localparam logic [3:0] S_SIFT_CMP = 4'd8;
    localparam logic [3:0] S_EMIT_REQ = 4'd9;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_size, n_size;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_merging, n_merging;
    logic             r_pend_valid, n_pend_valid;
    logic             r_out_valid, n_out_valid;
    logic [CNT_W-1:0] r_scount;

    logic             accept;
    logic             out_free;
    logic [CNT_W-1:0] cnt_eff;
    logic [CNT_W-1:0] fill_inc;
    logic [IDX_W-1:0] parent;
    logic [CNT_W-1:0] left, right;
    logic             pick_a, pick_b;
    logic [3:0]       push_done_state;
    t_cmd             cmd;

    assign accept      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // clamp the source count into its legal range
    always_comb begin
        if (r_scount == '0) begin
            cnt_eff = CNT_W'(1);
        end else if (r_scount > CNT_W'(MAX_SOURCES)) begin
            cnt_eff = CNT_W'(MAX_SOURCES);
        end else begin
            cnt_eff = r_scount;
        end
    end

    assign fill_inc        = r_fill + CNT_W'(1);
    assign parent          = (r_idx - IDX_W'(1)) >> 1;
    assign left            = {r_idx, 1'b1};
    assign right           = left + CNT_W'(1);
    assign pick_a          = i_stat.a_lt_c;
    assign pick_b          = (right < r_size) && (pick_a ? i_stat.b_lt_a : i_stat.b_lt_c);
    assign push_done_state = r_merging ? S_DEDUP : S_FILL_NXT;

    // next state and datapath commands
    always_comb begin
        n_state      = r_state;
        n_size       = r_size;
        n_fill       = r_fill;
        n_idx        = r_idx;
        n_merging    = r_merging;
        n_pend_valid = r_pend_valid;
        cmd          = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!i_in_empty && (r_size < CNT_W'(MAX_SOURCES))) begin
                        cmd.ld_carry_in = 1'b1;
                        cmd.in_src      = r_merging ? i_stat.popped_src : r_fill[IDX_W-1:0];
                        n_idx           = r_size[IDX_W-1:0];
                        n_state         = S_PUSH_RD;
                    end else begin
                        n_state = r_merging ? S_DEDUP : S_FILL_NXT;
                    end
                end
            end
            S_PUSH_RD: begin
                if (r_idx == '0) begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_addr = r_idx;
                    cmd.wr_sel  = WR_CARRY;
                    n_size      = r_size + CNT_W'(1);
                    n_state     = push_done_state;
                end else begin
                    cmd.rd_en     = 1'b1;
                    cmd.rd_addr_a = parent;
                    n_state       = S_PUSH_CMP;
                end
            end
            S_PUSH_CMP: begin
                // move the parent down while the new entry is smaller
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = r_idx;
                if (i_stat.c_lt_a) begin
                    cmd.wr_sel = WR_RDA;
                    n_idx      = parent;
                    n_state    = S_PUSH_RD;
                end else begin
                    cmd.wr_sel = WR_CARRY;
                    n_size     = r_size + CNT_W'(1);
                    n_state    = push_done_state;
                end
            end
            S_FILL_NXT: begin
                if (fill_inc < cnt_eff) begin
                    if (out_free) begin
                        cmd.out_ld   = 1'b1;
                        cmd.out_kind = KIND_REQUEST;
                        cmd.out_src  = fill_inc[IDX_W-1:0];
                        cmd.out_last = 1'b1;
                        n_fill       = fill_inc;
                        n_state      = S_IDLE;
                    end
                end else begin
                    n_fill    = fill_inc;
                    n_merging = 1'b1;
                    n_state   = S_ADV;
                end
            end
            S_DEDUP: begin
                if (r_pend_valid && i_stat.pair_eq) begin
                    cmd.ld_pending = i_stat.longer;
                    n_state        = S_ADV;
                end else if (!r_pend_valid) begin
                    cmd.ld_pending = 1'b1;
                    n_pend_valid   = 1'b1;
                    n_state        = S_ADV;
                end else if (out_free) begin
                    // flush the old pair, keep the new one
                    cmd.out_ld      = 1'b1;
                    cmd.out_kind    = KIND_RECORD;
                    cmd.out_pending = 1'b1;
                    cmd.ld_pending  = 1'b1;
                    n_state         = S_ADV;
                end
            end
            S_ADV: begin
                if (r_size != '0) begin
                    cmd.rd_en     = 1'b1;
                    cmd.rd_addr_b = '0;
                    cmd.rd_addr_a = IDX_W'(r_size - CNT_W'(1));
                    n_size        = r_size - CNT_W'(1);
                    n_state       = S_POP_LD;
                end else if (!r_pend_valid || out_free) begin
                    if (r_pend_valid) begin
                        cmd.out_ld      = 1'b1;
                        cmd.out_kind    = KIND_RECORD;
                        cmd.out_pending = 1'b1;
                        cmd.out_done    = 1'b1;
                        cmd.out_last    = 1'b1;
                    end
                    n_merging    = 1'b0;
                    n_fill       = '0;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            S_POP_LD: begin
                // root out, last entry becomes the carried value
                cmd.ld_popped_b = 1'b1;
                cmd.ld_carry_a  = 1'b1;
                n_idx           = '0;
                n_state         = (r_size == '0) ? S_EMIT_REQ : S_SIFT_RD;
            end
            S_SIFT_RD: begin
                if (left >= r_size) begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_addr = r_idx;
                    cmd.wr_sel  = WR_CARRY;
                    n_state     = S_EMIT_REQ;
                end else begin
                    cmd.rd_en     = 1'b1;
                    cmd.rd_addr_a = left[IDX_W-1:0];
                    cmd.rd_addr_b = right[IDX_W-1:0];
                    n_state       = S_SIFT_CMP;
                end
            end
            S_SIFT_CMP: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = r_idx;
                if (pick_b) begin
                    cmd.wr_sel = WR_RDB;
                    n_idx      = right[IDX_W-1:0];
                    n_state    = S_SIFT_RD;
                end else if (pick_a) begin
                    cmd.wr_sel = WR_RDA;
                    n_idx      = left[IDX_W-1:0];
                    n_state    = S_SIFT_RD;
                end else begin
                    cmd.wr_sel = WR_CARRY;
                    n_state    = S_EMIT_REQ;
                end
            end
            S_EMIT_REQ: begin
                if (out_free) begin
                    cmd.out_ld   = 1'b1;
                    cmd.out_kind = KIND_REQUEST;
                    cmd.out_src  = i_stat.popped_src;
                    cmd.out_last = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // hold the result until the sink takes it
    always_comb begin
        if (cmd.out_ld) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_size       <= '0;
            r_fill       <= '0;
            r_idx        <= '0;
            r_merging    <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_scount     <= CNT_W'(1);
        end else begin
            r_state      <= n_state;
            r_size       <= n_size;
            r_fill       <= n_fill;
            r_idx        <= n_idx;
            r_merging    <= n_merging;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_scount <= i_cfg_wdata;
            end
        end
    end

endmodule

// ===== design/kmd_dp.sv =====
// ----------------------------------------------------------------------------
// kmd_dp
// Heap storage, entry compares, popped and pending records, result register.
// ----------------------------------------------------------------------------
module kmd_dp (
    input  logic                      i_clk,
    input  logic [kmd_pkg::REC_W-1:0] i_rec,
    input  kmd_pkg::t_cmd             i_cmd,
    output kmd_pkg::t_stat            o_stat,
    output kmd_pkg::t_res             o_res
);
    import kmd_pkg::*;

    logic [ENT_W-1:0] r_carry;
    logic [ENT_W-1:0] r_popped;
    logic [REC_W-1:0] r_pending;
    t_res             r_res;
    logic [ENT_W-1:0] rd_a, rd_b;
    logic [ENT_W-1:0] wr_data;

    // heap entries
    kmd_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_SOURCES)
    ) u_heap (
        .i_clk     (i_clk),
        .i_we      (i_cmd.wr_en),
        .i_waddr   (i_cmd.wr_addr),
        .i_wdata   (wr_data),
        .i_re      (i_cmd.rd_en),
        .i_raddr_a (i_cmd.rd_addr_a),
        .i_raddr_b (i_cmd.rd_addr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    always_comb begin
        case (i_cmd.wr_sel)
            WR_RDA:  wr_data = rd_a;
            WR_RDB:  wr_data = rd_b;
            default: wr_data = r_carry;
        endcase
    end

    // record order then source index is one unsigned compare
    assign o_stat.c_lt_a     = r_carry < rd_a;
    assign o_stat.a_lt_c     = rd_a < r_carry;
    assign o_stat.b_lt_c     = rd_b < r_carry;
    assign o_stat.b_lt_a     = rd_b < rd_a;
    assign o_stat.pair_eq    = r_popped[ENT_W-1:IDX_W+SR_LSB] == r_pending[REC_W-1:SR_LSB];
    assign o_stat.longer     = r_popped[IDX_W+LEN_LSB +: ID_W] > r_pending[LEN_LSB +: ID_W];
    assign o_stat.popped_src = r_popped[IDX_W-1:0];

    // record registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_carry_in) begin
            r_carry <= {i_rec, i_cmd.in_src};
        end else if (i_cmd.ld_carry_a) begin
            r_carry <= rd_a;
        end
        if (i_cmd.ld_popped_b) begin
            r_popped <= rd_b;
        end
        if (i_cmd.ld_pending) begin
            r_pending <= r_popped[ENT_W-1:IDX_W];
        end
    end

    // result register, old pending value is sent on a flush
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_res.kind <= i_cmd.out_kind;
            r_res.src  <= i_cmd.out_src;
            r_res.rec  <= i_cmd.out_pending ? r_pending : '0;
            r_res.done <= i_cmd.out_done;
            r_res.last <= i_cmd.out_last;
        end
    end

    assign o_res = r_res;

endmodule

// ===== design/kway_merge_dedup_unit.sv =====
// ----------------------------------------------------------------------------
// kway_merge_dedup_unit
// K-way heap merge of sorted overlap records with per-pair dedup.
// ----------------------------------------------------------------------------
// After reset the unit takes the front record (or an empty mark) of each
// source in turn, then repeatedly pops the least record, reduces it into a
// one-per-read-pair pending record and requests the next record from the
// popped source. Every request result must be answered by exactly one input
// beat for that source. One beat is taken at a time. A step works on the
// heap in a single two-read-port RAM: a push sift-up over up to four levels
// and a pop sift-down over up to three levels, each level a read and then a
// compare-and-write, plus dedup and result issue. The result register
// lets the next beat enter while the last result of a step still waits at
// the output.
module kway_merge_dedup_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    kmd_in_if.sink                    i_in,
    kmd_out_if.source                 o_out,
    input  logic                      i_cfg_we,
    input  logic [kmd_pkg::CNT_W-1:0] i_cfg_wdata
);
    import kmd_pkg::*;

    t_cmd             cmd;
    t_stat            stat;
    t_res             res;
    logic [REC_W-1:0] in_rec;

    assign in_rec = {i_in.in_first_read, i_in.in_second_read, i_in.in_first_offset,
                     i_in.in_overlap_length, i_in.in_second_offset,
                     i_in.in_difference_count, i_in.in_strand};

    kmd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in.valid),
        .i_in_empty  (i_in.source_empty),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    kmd_dp u_dp (
        .i_clk  (i_clk),
        .i_rec  (in_rec),
        .i_cmd  (cmd),
        .o_stat (stat),
        .o_res  (res)
    );

    // unpack the result beat
    assign o_out.result_kind          = res.kind;
    assign o_out.request_source       = res.src;
    assign o_out.out_first_read       = res.rec[FR_LSB +: ID_W];
    assign o_out.out_second_read      = res.rec[SR_LSB +: ID_W];
    assign o_out.out_first_offset     = res.rec[FO_LSB +: ID_W];
    assign o_out.out_overlap_length   = res.rec[LEN_LSB +: ID_W];
    assign o_out.out_second_offset    = res.rec[SO_LSB +: ID_W];
    assign o_out.out_difference_count = res.rec[DC_LSB +: DIFF_W];
    assign o_out.out_strand           = res.rec[0];
    assign o_out.merge_done           = res.done;
    assign o_out.last_of_step         = res.last;

endmodule

// ===== design/kmd_checker.sv =====
// ----------------------------------------------------------------------------
// kmd_checker
// Port-level checks on result beats of the merge unit.
// ----------------------------------------------------------------------------
module kmd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_out_kind,
    input logic [kmd_pkg::IDX_W-1:0]   i_out_src,
    input logic [kmd_pkg::ID_W-1:0]    i_out_first_read,
    input logic                        i_out_done,
    input logic                        i_out_last
);

    // a stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind)
            && $stable(i_out_src) && $stable(i_out_first_read) && $stable(i_out_last))
        else $error("result beat changed while stalled");

    // a refill request carries no record and never ends the merge
    a_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind |-> i_out_first_read == '0 && !i_out_done && i_out_last)
        else $error("request beat with record data");

    // a record beat names no source
    a_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_kind |-> i_out_src == '0)
        else $error("record beat with source");

    // no new input while a step still owes results
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input taken mid-step");

    // merge done closes a step
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_done |-> i_out_last && !i_out_kind)
        else $error("merge done on a non-final beat");

endmodule

bind kway_merge_dedup_unit kmd_checker u_kmd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_kind       (o_out.result_kind),
    .i_out_src        (o_out.request_source),
    .i_out_first_read (o_out.out_first_read),
    .i_out_done       (o_out.merge_done),
    .i_out_last       (o_out.last_of_step)
);
